FILE: src/scc_pkg.sv
// shared request, status codes and result word for the component search block
package scc_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_COMP  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NO_OUT = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] vertex;
    logic        eoc;
    logic        eoa;
  } result_t;

endpackage

FILE: src/strongly_connected_components.sv
// top level: edge store, tarjan search sequencer and component readout
// add edge links the edge in S_ADD2; range or full errors and early reads answer from S_IDLE
// compute: vertex init, depth-first walk over the edges, member pops, then vertex renumbering
// read: scans the label memory from the last position
// clear: one first-edge entry per cycle through its ram write port
// reset runs the same first-edge clearing pass (busy high); results are a one-cycle done_o
// strobe and the receiver cannot stall them
module strongly_connected_components #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [10:0] src_vertex_i,
  input  logic [10:0] dst_vertex_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [10:0] component_total_o,
  output logic [10:0] vertex_out_o,
  output logic        end_of_component_o,
  output logic        end_of_all_o
);
  import scc_pkg::*;

  // vertex index, vertex number / count, edge address and edge pointer widths
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW  = $clog2(MAX_EDGES + 1);
  localparam int WW  = (NW > 11) ? NW : 11;
  localparam logic [LW-1:0] EDGE_NULL = LW'(MAX_EDGES);

  typedef struct packed {
    logic [NW-1:0] target;
    logic [LW-1:0] link;
  } edge_word_t;

  // one call frame: vertex, next edge to try, low link and visit number
  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [LW-1:0] nxt_edge;
    logic [NW-1:0] low;
    logic [NW-1:0] vis;
  } frame_t;

  typedef struct packed {
    logic          mapped;
    logic [VW-1:0] value;
  } remap_t;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_ADD2   = 5'd2;
  localparam logic [4:0] S_INIT   = 5'd3;
  localparam logic [4:0] S_ROOT   = 5'd4;
  localparam logic [4:0] S_ROOT2  = 5'd5;
  localparam logic [4:0] S_ENTER  = 5'd6;
  localparam logic [4:0] S_ENTER2 = 5'd7;
  localparam logic [4:0] S_EDGE   = 5'd8;
  localparam logic [4:0] S_EDGE2  = 5'd9;
  localparam logic [4:0] S_EDGE3  = 5'd10;
  localparam logic [4:0] S_POP    = 5'd11;
  localparam logic [4:0] S_PM     = 5'd12;
  localparam logic [4:0] S_PM2    = 5'd13;
  localparam logic [4:0] S_PAR    = 5'd14;
  localparam logic [4:0] S_PAR2   = 5'd15;
  localparam logic [4:0] S_REN    = 5'd16;
  localparam logic [4:0] S_REN2   = 5'd17;
  localparam logic [4:0] S_REN3   = 5'd18;
  localparam logic [4:0] S_RDV    = 5'd19;
  localparam logic [4:0] S_RDV2   = 5'd20;
  localparam logic [4:0] S_RDU    = 5'd21;
  localparam logic [4:0] S_RDU2   = 5'd22;

  // control state
  logic [4:0]    state_q, state_d;
  logic [NW-1:0] idx_q, idx_d;          // sweep / root / renumber / read scan position
  logic          clr_resp_q, clr_resp_d;
  logic [LW-1:0] stored_q, stored_d;
  logic          ready_q, ready_d;
  logic [10:0]   vcount_q, vcount_d;
  logic [NW-1:0] leader_q, leader_d;
  logic [NW-1:0] scan_q, scan_d;
  logic [NW-1:0] cc_q, cc_d;
  logic [NW-1:0] vc_q, vc_d;            // visit counter, then next renumbered label
  logic [NW-1:0] mtop_q, mtop_d;
  logic [NW-1:0] ftop_q, ftop_d;
  logic          done_q, done_d;

  // working registers of the top frame and scratch
  logic [VW-1:0] cv_q, cv_d;
  logic [LW-1:0] ce_q, ce_d;
  logic [NW-1:0] clow_q, clow_d;
  logic [NW-1:0] cvis_q, cvis_d;
  logic [VW-1:0] ew_q, ew_d;
  logic [NW-1:0] fv_q, fv_d;
  result_t       res_q, res_d;
  logic [10:0]   total_q, total_d;

  // ram ports
  logic           edge_we;
  logic [EAW-1:0] edge_wa, edge_ra;
  edge_word_t     edge_wd, edge_rd;
  logic           fe_we;
  logic [VW-1:0]  fe_wa, fe_ra;
  logic [LW-1:0]  fe_wd, fe_rd;
  logic           vo_we;
  logic [VW-1:0]  vo_wa, vo_ra;
  logic [NW-1:0]  vo_wd, vo_rd;
  logic           cl_we;
  logic [VW-1:0]  cl_wa, cl_ra;
  logic           cl_wd, cl_rd;
  logic           lb_we;
  logic [VW-1:0]  lb_wa, lb_ra;
  logic [VW-1:0]  lb_wd, lb_rd;
  logic           ms_we;
  logic [VW-1:0]  ms_wa, ms_ra;
  logic [VW-1:0]  ms_wd, ms_rd;
  logic           fr_we;
  logic [VW-1:0]  fr_wa, fr_ra;
  frame_t         fr_wd, fr_rd;
  logic           rm_we;
  logic [VW-1:0]  rm_wa, rm_ra;
  remap_t         rm_wd, rm_rd;

  logic [NW-1:0] nv;                    // vertices in use
  logic          src_ok, dst_ok;
  logic [NW-1:0] ftop_m1, mtop_m1, vc_p1, leader_p1, fv_p1, w_m1;

  assign nv = (WW'(vcount_q) > WW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
  assign src_ok = (src_vertex_i != 11'd0) && (WW'(src_vertex_i) <= WW'(nv));
  assign dst_ok = (dst_vertex_i != 11'd0) && (WW'(dst_vertex_i) <= WW'(nv));
  assign ftop_m1   = ftop_q - 1'b1;
  assign mtop_m1   = mtop_q - 1'b1;
  assign vc_p1     = vc_q + 1'b1;
  assign leader_p1 = leader_q + 1'b1;
  assign fv_p1     = fv_q + 1'b1;
  assign w_m1      = edge_rd.target - 1'b1;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    clr_resp_d = clr_resp_q;
    stored_d   = stored_q;
    ready_d    = ready_q;
    vcount_d   = vcount_q;
    leader_d   = leader_q;
    scan_d     = scan_q;
    cc_d       = cc_q;
    vc_d       = vc_q;
    mtop_d     = mtop_q;
    ftop_d     = ftop_q;
    done_d     = 1'b0;
    cv_d       = cv_q;
    ce_d       = ce_q;
    clow_d     = clow_q;
    cvis_d     = cvis_q;
    ew_d       = ew_q;
    fv_d       = fv_q;
    res_d      = res_q;
    total_d    = total_q;

    edge_we = 1'b0; edge_wa = stored_q[EAW-1:0]; edge_wd = '{fv_q, fe_rd};
    edge_ra = ce_q[EAW-1:0];
    fe_we = 1'b0; fe_wa = idx_q[VW-1:0]; fe_wd = EDGE_NULL; fe_ra = ew_q;
    vo_we = 1'b0; vo_wa = idx_q[VW-1:0]; vo_wd = '0; vo_ra = idx_q[VW-1:0];
    cl_we = 1'b0; cl_wa = idx_q[VW-1:0]; cl_wd = 1'b0; cl_ra = ew_q;
    lb_we = 1'b0; lb_wa = idx_q[VW-1:0]; lb_wd = '0; lb_ra = idx_q[VW-1:0];
    ms_we = 1'b0; ms_wa = mtop_q[VW-1:0]; ms_wd = ew_q; ms_ra = mtop_m1[VW-1:0];
    fr_we = 1'b0; fr_wa = ftop_m1[VW-1:0]; fr_wd = '{cv_q, ce_q, clow_q, cvis_q};
    fr_ra = ftop_m1[VW-1:0];
    rm_we = 1'b0; rm_wa = ew_q; rm_wd = '{1'b0, '0}; rm_ra = lb_rd;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = '{ST_OK, 11'd0, 1'b0, 1'b0};
          case (req_type_i)
            REQ_ADD: begin
              if (!(src_ok && dst_ok)) begin
                res_d.status = ST_RANGE;
                done_d = 1'b1;
              end else if (stored_q == EDGE_NULL) begin
                res_d.status = ST_FULL;
                done_d = 1'b1;
              end else begin
                ew_d    = VW'(src_vertex_i - 11'd1);
                fe_ra   = VW'(src_vertex_i - 11'd1);
                fv_d    = NW'(dst_vertex_i);
                state_d = S_ADD2;
              end
            end
            REQ_COMP: begin
              idx_d   = '0;
              vc_d    = '0;
              cc_d    = '0;
              mtop_d  = '0;
              ftop_d  = '0;
              state_d = S_INIT;
            end
            REQ_READ: begin
              if (!ready_q || (leader_q >= cc_q)) begin
                res_d.status = ST_NO_OUT;
                done_d = 1'b1;
              end else begin
                idx_d   = scan_q;
                state_d = S_RDV;
              end
            end
            REQ_CLEAR: begin
              idx_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = S_CLR;
            end
            default: ;
          endcase
        end
      end
      // first-edge clearing pass, also run after reset
      S_CLR: begin
        fe_we = 1'b1;
        if (idx_q == NW'(MAX_VERTICES - 1)) begin
          stored_d   = '0;
          ready_d    = 1'b0;
          done_d     = clr_resp_q;
          clr_resp_d = 1'b0;
          state_d    = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // link the new edge in front of the source's list
      S_ADD2: begin
        edge_we  = 1'b1;
        fe_we    = 1'b1;
        fe_wa    = ew_q;
        fe_wd    = stored_q;
        stored_d = stored_q + 1'b1;
        ready_d  = 1'b0;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      // mark all used vertices unvisited, open and unmapped
      S_INIT: begin
        if (idx_q == nv) begin
          idx_d   = '0;
          state_d = S_ROOT;
        end else begin
          vo_we = 1'b1;
          cl_we = 1'b1;
          rm_we = 1'b1;
          rm_wa = idx_q[VW-1:0];
          idx_d = idx_q + 1'b1;
        end
      end
      S_ROOT: begin
        if (idx_q == nv) begin
          idx_d   = '0;
          vc_d    = '0;
          state_d = S_REN;
        end else begin
          state_d = S_ROOT2;
        end
      end
      S_ROOT2: begin
        if (vo_rd != '0) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ROOT;
        end else begin
          ew_d    = idx_q[VW-1:0];
          state_d = S_ENTER;
        end
      end
      // number the vertex, push it, save the parent frame
      S_ENTER: begin
        vc_d   = vc_p1;
        vo_we  = 1'b1;
        vo_wa  = ew_q;
        vo_wd  = vc_p1;
        ms_we  = 1'b1;
        mtop_d = mtop_q + 1'b1;
        fr_we  = (ftop_q != '0);
        state_d = S_ENTER2;
      end
      S_ENTER2: begin
        cv_d    = ew_q;
        ce_d    = fe_rd;
        clow_d  = vc_q;
        cvis_d  = vc_q;
        ftop_d  = ftop_q + 1'b1;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        state_d = (ce_q == EDGE_NULL) ? S_POP : S_EDGE2;
      end
      S_EDGE2: begin
        ce_d = edge_rd.link;
        if ((edge_rd.target == '0) || (edge_rd.target > nv)) begin
          state_d = S_EDGE;
        end else begin
          ew_d    = w_m1[VW-1:0];
          vo_ra   = w_m1[VW-1:0];
          cl_ra   = w_m1[VW-1:0];
          state_d = S_EDGE3;
        end
      end
      S_EDGE3: begin
        if (vo_rd == '0) begin
          state_d = S_ENTER;
        end else begin
          if (!cl_rd && (vo_rd < clow_q)) begin
            clow_d = vo_rd;
          end
          state_d = S_EDGE;
        end
      end
      S_POP: begin
        ftop_d  = ftop_m1;
        state_d = (clow_q == cvis_q) ? S_PM : S_PAR;
      end
      // pop members down to the component root
      S_PM: begin
        if (mtop_q == '0) begin
          cc_d    = cc_q + 1'b1;
          state_d = S_PAR;
        end else begin
          mtop_d  = mtop_m1;
          state_d = S_PM2;
        end
      end
      S_PM2: begin
        cl_we = 1'b1;
        cl_wa = ms_rd;
        cl_wd = 1'b1;
        lb_we = 1'b1;
        lb_wa = ms_rd;
        lb_wd = cc_q[VW-1:0];
        if (ms_rd == cv_q) begin
          cc_d    = cc_q + 1'b1;
          state_d = S_PAR;
        end else begin
          state_d = S_PM;
        end
      end
      S_PAR: begin
        if (ftop_q == '0) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ROOT;
        end else begin
          state_d = S_PAR2;
        end
      end
      // resume the parent, fold in the child's low link
      S_PAR2: begin
        cv_d    = fr_rd.vtx;
        ce_d    = fr_rd.nxt_edge;
        cvis_d  = fr_rd.vis;
        clow_d  = (clow_q < fr_rd.low) ? clow_q : fr_rd.low;
        state_d = S_EDGE;
      end
      // renumber components by smallest vertex
      S_REN: begin
        if (idx_q == nv) begin
          ready_d  = 1'b1;
          leader_d = '0;
          scan_d   = '0;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_REN2;
        end
      end
      S_REN2: begin
        ew_d    = lb_rd;
        state_d = S_REN3;
      end
      S_REN3: begin
        lb_we = 1'b1;
        if (!rm_rd.mapped) begin
          rm_we = 1'b1;
          rm_wd = '{1'b1, vc_q[VW-1:0]};
          lb_wd = vc_q[VW-1:0];
          vc_d  = vc_p1;
        end else begin
          lb_wd = rm_rd.value;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_REN;
      end
      // find the next member of the current component
      S_RDV: begin
        if (idx_q >= nv) begin
          res_d.status = ST_NO_OUT;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RDV2;
        end
      end
      S_RDV2: begin
        if (lb_rd == leader_q[VW-1:0]) begin
          fv_d    = idx_q;
          state_d = S_RDU;
        end else begin
          state_d = S_RDV;
        end
        idx_d = idx_q + 1'b1;
      end
      // look ahead for one more member to flag the end of the component
      S_RDU: begin
        if (idx_q >= nv) begin
          res_d.vertex = 11'(fv_p1);
          res_d.eoc    = 1'b1;
          res_d.eoa    = (leader_p1 >= cc_q);
          leader_d     = leader_p1;
          scan_d       = '0;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_RDU2;
        end
      end
      S_RDU2: begin
        if (lb_rd == leader_q[VW-1:0]) begin
          scan_d       = idx_q;
          res_d.vertex = 11'(fv_p1);
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RDU;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
      ready_d  = 1'b0;
    end

    total_d = ready_d ? 11'(cc_d) : 11'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      idx_q      <= '0;
      clr_resp_q <= 1'b0;
      stored_q   <= '0;
      ready_q    <= 1'b0;
      vcount_q   <= 11'd1;
      leader_q   <= '0;
      scan_q     <= '0;
      cc_q       <= '0;
      vc_q       <= '0;
      mtop_q     <= '0;
      ftop_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      clr_resp_q <= clr_resp_d;
      stored_q   <= stored_d;
      ready_q    <= ready_d;
      vcount_q   <= vcount_d;
      leader_q   <= leader_d;
      scan_q     <= scan_d;
      cc_q       <= cc_d;
      vc_q       <= vc_d;
      mtop_q     <= mtop_d;
      ftop_q     <= ftop_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cv_q    <= cv_d;
    ce_q    <= ce_d;
    clow_q  <= clow_d;
    cvis_q  <= cvis_d;
    ew_q    <= ew_d;
    fv_q    <= fv_d;
    res_q   <= res_d;
    total_q <= total_d;
  end

  // state memories
  scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NW + LW)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(edge_wd),
    .raddr_i(edge_ra), .rdata_o(edge_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(LW)) u_first (
    .clk_i, .we_i(fe_we), .waddr_i(fe_wa), .wdata_i(fe_wd),
    .raddr_i(fe_ra), .rdata_o(fe_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(NW)) u_visit (
    .clk_i, .we_i(vo_we), .waddr_i(vo_wa), .wdata_i(vo_wd),
    .raddr_i(vo_ra), .rdata_o(vo_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(1)) u_closed (
    .clk_i, .we_i(cl_we), .waddr_i(cl_wa), .wdata_i(cl_wd),
    .raddr_i(cl_ra), .rdata_o(cl_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_label (
    .clk_i, .we_i(lb_we), .waddr_i(lb_wa), .wdata_i(lb_wd),
    .raddr_i(lb_ra), .rdata_o(lb_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_members (
    .clk_i, .we_i(ms_we), .waddr_i(ms_wa), .wdata_i(ms_wd),
    .raddr_i(ms_ra), .rdata_o(ms_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW + LW + 2 * NW)) u_frames (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd),
    .raddr_i(fr_ra), .rdata_o(fr_rd)
  );
  scc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW + 1)) u_remap (
    .clk_i, .we_i(rm_we), .waddr_i(rm_wa), .wdata_i(rm_wd),
    .raddr_i(rm_ra), .rdata_o(rm_rd)
  );

  assign done_o             = done_q;
  assign status_o           = res_q.status;
  assign component_total_o  = total_q;
  assign vertex_out_o       = res_q.vertex;
  assign end_of_component_o = res_q.eoc;
  assign end_of_all_o       = res_q.eoa;

  // every vertex held in a frame is also on the member stack
  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mtop_q >= ftop_q) else $error("frame stack deeper than member stack");

  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= EDGE_NULL) else $error("edge count past capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("word delivered while busy");

  a_vertex_needs_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (vertex_out_o != 11'd0)) |-> (component_total_o != 11'd0))
    else $error("vertex word without components");

endmodule

FILE: src/scc_ram.sv
// simple dual port ram, one write and one registered read per cycle
module scc_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
